// ===== design/hcpg_pkg.sv =====
// Package for the Hermite curve point generator: shared types, state codes
// and fixed-point constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hcpg_pkg;

  localparam int BASIS_FRAC   = 16;
  localparam int T_W          = BASIS_FRAC + 1;   // t and the basis values span [0, 1]
  localparam int IDX_W        = 6;
  localparam int COORD_W      = 32;
  localparam int DIV_STEPS    = T_W;              // quotient bits of 2^16 / N
  localparam int DIV_CNT_W    = 5;

  localparam logic [IDX_W-1:0]     DIV_COUNT_RESET = 6'd16;
  localparam logic [T_W-1:0]       BASIS_ONE       = 17'h10000;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP   = 5'(DIV_STEPS - 1);
  localparam logic [COORD_W-1:0]   COORD_MAX       = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0]   COORD_MIN       = 32'h8000_0000;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIVIDE,
    SEQ_ISSUE,
    SEQ_REJECT
  } seq_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_pos_x;
    logic signed [COORD_W-1:0] start_pos_y;
    logic signed [COORD_W-1:0] start_tan_x;
    logic signed [COORD_W-1:0] start_tan_y;
    logic signed [COORD_W-1:0] end_pos_x;
    logic signed [COORD_W-1:0] end_pos_y;
    logic signed [COORD_W-1:0] end_tan_x;
    logic signed [COORD_W-1:0] end_tan_y;
  } coords_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
    logic             rejected;
  } meta_t;

  typedef struct packed {
    logic             valid;
    logic [T_W-1:0]   t;
    meta_t            meta;
  } seq_item_t;

  typedef struct packed {
    logic [T_W-1:0] h00;
    logic [T_W-1:0] h01;
    logic [T_W-1:0] h10;
    logic [T_W-1:0] h11;   // magnitude; this basis term is subtracted
  } basis_t;

endpackage

`default_nettype wire

// ===== design/hcpg_if.sv =====
// Channel interfaces of the Hermite curve point generator: curve requests in,
// curve points out. Depends on hcpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hcpg_in_if;
  import hcpg_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_pos_x;
  logic signed [COORD_W-1:0] start_pos_y;
  logic signed [COORD_W-1:0] start_tan_x;
  logic signed [COORD_W-1:0] start_tan_y;
  logic signed [COORD_W-1:0] end_pos_x;
  logic signed [COORD_W-1:0] end_pos_y;
  logic signed [COORD_W-1:0] end_tan_x;
  logic signed [COORD_W-1:0] end_tan_y;

  modport source (
    output valid, start_pos_x, start_pos_y, start_tan_x, start_tan_y,
           end_pos_x, end_pos_y, end_tan_x, end_tan_y,
    input  ready
  );

  modport sink (
    input  valid, start_pos_x, start_pos_y, start_tan_x, start_tan_y,
           end_pos_x, end_pos_y, end_tan_x, end_tan_y,
    output ready
  );
endinterface

interface hcpg_out_if;
  import hcpg_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [IDX_W-1:0]          point_index;
  logic                      is_last;
  logic                      rejected;

  modport source (
    output valid, point_x, point_y, point_index, is_last, rejected,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_index, is_last, rejected,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/hcpg_seq.sv =====
// Request sequencer: latches a curve request, finds 2^16 / N bit-serially and
// then steps t = round(i / N) in Q1.16 for i = 0..N. Depends on hcpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcpg_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire hcpg_pkg::coords_t   in_coords,
  input  wire logic [5:0]          div_count,
  input  wire logic                adv,
  output      hcpg_pkg::seq_item_t item,
  output      hcpg_pkg::coords_t   req_coords
);
  import hcpg_pkg::*;

  seq_state_t           state_r, state_nxt;
  logic [IDX_W-1:0]     n_r, n_nxt;
  coords_t              req_r, req_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [IDX_W:0]       rem_r, rem_nxt;
  logic [T_W-1:0]       quo_r, quo_nxt;
  logic [T_W-1:0]       t_r, t_nxt;
  logic [IDX_W-1:0]     acc_r, acc_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;

  logic [IDX_W:0]       trial;
  logic                 qbit;
  logic [IDX_W:0]       acc_sum;
  logic                 at_last;

  assign at_last    = (idx_r == n_r);
  assign req_coords = req_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: begin
        if (in_valid) begin
          state_nxt = (div_count == '0) ? SEQ_REJECT : SEQ_DIVIDE;
        end
      end
      SEQ_DIVIDE: begin
        if (div_cnt_r == '0) begin
          state_nxt = SEQ_ISSUE;
        end
      end
      SEQ_ISSUE: begin
        if (adv && at_last) begin
          state_nxt = SEQ_IDLE;
        end
      end
      SEQ_REJECT: begin
        if (adv) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready            = 1'b0;
    item.valid          = 1'b0;
    item.t              = t_r;
    item.meta.index     = idx_r;
    item.meta.last      = at_last;
    item.meta.rejected  = 1'b0;
    case (state_r)
      SEQ_IDLE:   in_ready = 1'b1;
      SEQ_DIVIDE: item.valid = 1'b0;
      SEQ_ISSUE:  item.valid = 1'b1;
      SEQ_REJECT: begin
        item.valid         = 1'b1;
        item.t             = '0;
        item.meta.index    = '0;
        item.meta.last     = 1'b1;
        item.meta.rejected = 1'b1;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // Restoring division of 2^16 by N, then the running quotient/remainder walk.
  always_comb begin
    n_nxt       = n_r;
    req_nxt     = req_r;
    div_cnt_nxt = div_cnt_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    t_nxt       = t_r;
    acc_nxt     = acc_r;
    idx_nxt     = idx_r;
    trial       = {rem_r[IDX_W-1:0], (div_cnt_r == DIV_LAST_STEP)};
    qbit        = (trial >= {1'b0, n_r});
    acc_sum     = {1'b0, acc_r} + {1'b0, rem_r[IDX_W-1:0]};
    case (state_r)
      SEQ_IDLE: begin
        if (in_valid) begin
          n_nxt       = div_count;
          req_nxt     = in_coords;
          div_cnt_nxt = DIV_LAST_STEP;
          rem_nxt     = '0;
          quo_nxt     = '0;
        end
      end
      SEQ_DIVIDE: begin
        rem_nxt     = qbit ? (trial - {1'b0, n_r}) : trial;
        quo_nxt     = {quo_r[T_W-2:0], qbit};
        div_cnt_nxt = div_cnt_r - 1'b1;
        t_nxt       = '0;
        acc_nxt     = n_r >> 1;
        idx_nxt     = '0;
      end
      SEQ_ISSUE: begin
        if (adv) begin
          idx_nxt = idx_r + 1'b1;
          // The remainder stays below 2N, so one compare and subtract suffices.
          if (acc_sum >= {1'b0, n_r}) begin
            acc_nxt = IDX_W'(acc_sum - {1'b0, n_r});
            t_nxt   = t_r + quo_r + 1'b1;
          end else begin
            acc_nxt = acc_sum[IDX_W-1:0];
            t_nxt   = t_r + quo_r;
          end
        end
      end
      SEQ_REJECT: begin
        n_nxt = n_r;
      end
      default: n_nxt = n_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    req_r     <= req_nxt;
    div_cnt_r <= div_cnt_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    t_r       <= t_nxt;
    acc_r     <= acc_nxt;
    idx_r     <= idx_nxt;
  end

endmodule

`default_nettype wire

// ===== design/hcpg_basis.sv =====
// Three-stage pipeline from t to the four rounded Hermite basis values in
// Q1.16. Depends on hcpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcpg_basis (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire hcpg_pkg::seq_item_t item,
  input  wire hcpg_pkg::coords_t   coords_in,
  output      logic                valid_out,
  output      hcpg_pkg::basis_t    basis_out,
  output      hcpg_pkg::meta_t     meta_out,
  output      hcpg_pkg::coords_t   coords_out
);
  import hcpg_pkg::*;

  localparam int SQ_W   = 2 * T_W;         // squares of values up to 1.0
  localparam int PROD_W = 52;              // cubes scaled by 2^48 plus headroom
  localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(64'h8000_0000);

  // Stage 1: squares and the linear factors
  logic             v1_r, v2_r, v3_r;
  logic [SQ_W-1:0]  uu_r, tt_r, ut_r;
  logic [SQ_W-1:0]  uu_nxt, tt_nxt, ut_nxt;
  logic [T_W-1:0]   t1_r, u;
  logic [T_W:0]     w00_r, w01_r, w00_nxt, w01_nxt;
  meta_t            meta1_r, meta2_r, meta3_r;
  coords_t          crd1_r, crd2_r, crd3_r;

  // Stage 2: cubic products scaled by 2^48
  logic [PROD_W-1:0] p00_r, p01_r, p10_r, p11_r;
  logic [PROD_W-1:0] p00_nxt, p01_nxt, p10_nxt, p11_nxt;

  // Stage 3: rounded basis values
  basis_t            basis_r, basis_nxt;
  logic [PROD_W-1:0] r00, r01, r10, r11;

  assign u       = BASIS_ONE - item.t;
  assign uu_nxt  = {{T_W{1'b0}}, u} * {{T_W{1'b0}}, u};
  assign tt_nxt  = {{T_W{1'b0}}, item.t} * {{T_W{1'b0}}, item.t};
  assign ut_nxt  = {{T_W{1'b0}}, u} * {{T_W{1'b0}}, item.t};
  assign w00_nxt = {item.t, 1'b0} + {1'b0, BASIS_ONE};
  // 3 - 2t with t at most 1; the sum stays within T_W+1 bits.
  assign w01_nxt = {BASIS_ONE, 1'b0} + {1'b0, BASIS_ONE} - {item.t, 1'b0};

  assign p00_nxt = {{(PROD_W-SQ_W){1'b0}}, uu_r} * {{(PROD_W-T_W-1){1'b0}}, w00_r};
  assign p01_nxt = {{(PROD_W-SQ_W){1'b0}}, tt_r} * {{(PROD_W-T_W-1){1'b0}}, w01_r};
  assign p10_nxt = {{(PROD_W-SQ_W){1'b0}}, uu_r} * {{(PROD_W-T_W){1'b0}}, t1_r};
  assign p11_nxt = {{(PROD_W-SQ_W){1'b0}}, ut_r} * {{(PROD_W-T_W){1'b0}}, t1_r};

  assign r00 = p00_r + HALF_LSB;
  assign r01 = p01_r + HALF_LSB;
  assign r10 = p10_r + HALF_LSB;
  assign r11 = p11_r + HALF_LSB;
  assign basis_nxt.h00 = r00[2*BASIS_FRAC +: T_W];
  assign basis_nxt.h01 = r01[2*BASIS_FRAC +: T_W];
  assign basis_nxt.h10 = r10[2*BASIS_FRAC +: T_W];
  assign basis_nxt.h11 = r11[2*BASIS_FRAC +: T_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= item.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      uu_r    <= uu_nxt;
      tt_r    <= tt_nxt;
      ut_r    <= ut_nxt;
      t1_r    <= item.t;
      w00_r   <= w00_nxt;
      w01_r   <= w01_nxt;
      meta1_r <= item.meta;
      crd1_r  <= coords_in;
      p00_r   <= p00_nxt;
      p01_r   <= p01_nxt;
      p10_r   <= p10_nxt;
      p11_r   <= p11_nxt;
      meta2_r <= meta1_r;
      crd2_r  <= crd1_r;
      basis_r <= basis_nxt;
      meta3_r <= meta2_r;
      crd3_r  <= crd2_r;
    end
  end

  assign valid_out  = v3_r;
  assign basis_out  = basis_r;
  assign meta_out   = meta3_r;
  assign coords_out = crd3_r;

endmodule

`default_nettype wire

// ===== design/hcpg_blend.sv =====
// Four-stage pipeline that weights the curve vectors by the basis values,
// sums, rounds to Q16.16 and saturates. The last stage is the output register.
// Depends on hcpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcpg_blend (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire logic                     valid_in,
  input  wire hcpg_pkg::basis_t         basis_in,
  input  wire hcpg_pkg::meta_t          meta_in,
  input  wire hcpg_pkg::coords_t        coords_in,
  output      logic                     valid_out,
  output      logic signed [31:0]       point_x,
  output      logic signed [31:0]       point_y,
  output      hcpg_pkg::meta_t          meta_out
);
  import hcpg_pkg::*;

  localparam int MUL_W = T_W + 1 + COORD_W;   // signed basis times coordinate
  localparam int SUM_W = 52;
  localparam int RES_W = SUM_W - BASIS_FRAC;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (BASIS_FRAC - 1);

  function automatic logic signed [MUL_W-1:0] wmul(logic [T_W-1:0] h,
                                                   logic signed [COORD_W-1:0] c);
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
    a = MUL_W'($signed({1'b0, h}));
    b = MUL_W'(c);
    return a * b;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat(logic signed [RES_W-1:0] r);
    logic fits;
    fits = (r[RES_W-1:COORD_W-1] == '0) || (r[RES_W-1:COORD_W-1] == '1);
    if (fits) begin
      return r[COORD_W-1:0];
    end else if (r[RES_W-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

  logic v4_r, v5_r, v6_r, v7_r;
  meta_t meta4_r, meta5_r, meta6_r, meta7_r;

  // Stage 4: eight weighted coordinates
  logic signed [MUL_W-1:0] mx00_r, mx01_r, mx10_r, mx11_r;
  logic signed [MUL_W-1:0] my00_r, my01_r, my10_r, my11_r;

  // Stage 5: pair sums; the end-tangent term enters with a minus sign
  logic signed [SUM_W-1:0] ax_r, bx_r, ay_r, by_r;
  logic signed [SUM_W-1:0] ax_nxt, bx_nxt, ay_nxt, by_nxt;

  // Stage 6: full sum plus half an output LSB
  logic signed [SUM_W-1:0] sx_r, sy_r, sx_nxt, sy_nxt;

  // Stage 7: rounded, saturated point
  logic signed [COORD_W-1:0] px_r, py_r, px_nxt, py_nxt;
  logic signed [RES_W-1:0]   rx, ry;

  assign ax_nxt = SUM_W'(mx00_r) + SUM_W'(mx01_r);
  assign bx_nxt = SUM_W'(mx10_r) - SUM_W'(mx11_r);
  assign ay_nxt = SUM_W'(my00_r) + SUM_W'(my01_r);
  assign by_nxt = SUM_W'(my10_r) - SUM_W'(my11_r);

  assign sx_nxt = ax_r + bx_r + ROUND_HALF;
  assign sy_nxt = ay_r + by_r + ROUND_HALF;

  assign rx = sx_r[SUM_W-1:BASIS_FRAC];
  assign ry = sy_r[SUM_W-1:BASIS_FRAC];
  assign px_nxt = meta6_r.rejected ? '0 : sat(rx);
  assign py_nxt = meta6_r.rejected ? '0 : sat(ry);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (adv) begin
      v4_r <= valid_in;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx00_r  <= wmul(basis_in.h00, coords_in.start_pos_x);
      mx01_r  <= wmul(basis_in.h01, coords_in.end_pos_x);
      mx10_r  <= wmul(basis_in.h10, coords_in.start_tan_x);
      mx11_r  <= wmul(basis_in.h11, coords_in.end_tan_x);
      my00_r  <= wmul(basis_in.h00, coords_in.start_pos_y);
      my01_r  <= wmul(basis_in.h01, coords_in.end_pos_y);
      my10_r  <= wmul(basis_in.h10, coords_in.start_tan_y);
      my11_r  <= wmul(basis_in.h11, coords_in.end_tan_y);
      meta4_r <= meta_in;
      ax_r    <= ax_nxt;
      bx_r    <= bx_nxt;
      ay_r    <= ay_nxt;
      by_r    <= by_nxt;
      meta5_r <= meta4_r;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      meta6_r <= meta5_r;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      meta7_r <= meta6_r;
    end
  end

  assign valid_out = v7_r;
  assign point_x   = px_r;
  assign point_y   = py_r;
  assign meta_out  = meta7_r;

endmodule

`default_nettype wire

// ===== design/hermite_curve_point_generator.sv =====
// Hermite curve point generator: one request in, N+1 points out at one per cycle while
// the output is not stalled. After the request transaction the sequencer runs the
// bit-serial 2^16 / N divider, then the points pass through 7 pipeline stages.
// The sequencer takes no new request until the last point of the current one has
// issued; a rejected request yields one flagged result.
// Reset clears the controls and pipeline valid bits; division_count resets to 16.
`timescale 1ns / 1ps
`default_nettype none

module hermite_curve_point_generator #(
  parameter int MAX_DIVISIONS = 63
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  hcpg_in_if.sink         in_ch,
  hcpg_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_wdata
);
  import hcpg_pkg::*;

  localparam logic [IDX_W-1:0] MAX_DIV = IDX_W'(MAX_DIVISIONS);

  logic [IDX_W-1:0] div_count_r;
  logic [IDX_W-1:0] div_count_eff;
  logic             adv;
  logic             out_valid;
  coords_t          in_coords;
  coords_t          req_coords;
  seq_item_t        item;
  logic             b_valid;
  basis_t           b_basis;
  meta_t            b_meta;
  coords_t          b_coords;
  meta_t            o_meta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_count_r <= DIV_COUNT_RESET;
    end else if (cfg_we) begin
      div_count_r <= cfg_wdata;
    end
  end

  assign div_count_eff = (div_count_r > MAX_DIV) ? MAX_DIV : div_count_r;

  // The whole pipeline moves whenever the output register is free or drained.
  assign adv = !out_valid || out_ch.ready;

  assign in_coords.start_pos_x = in_ch.start_pos_x;
  assign in_coords.start_pos_y = in_ch.start_pos_y;
  assign in_coords.start_tan_x = in_ch.start_tan_x;
  assign in_coords.start_tan_y = in_ch.start_tan_y;
  assign in_coords.end_pos_x   = in_ch.end_pos_x;
  assign in_coords.end_pos_y   = in_ch.end_pos_y;
  assign in_coords.end_tan_x   = in_ch.end_tan_x;
  assign in_coords.end_tan_y   = in_ch.end_tan_y;

  hcpg_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_coords  (in_coords),
    .div_count  (div_count_eff),
    .adv        (adv),
    .item       (item),
    .req_coords (req_coords)
  );

  hcpg_basis u_basis (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .item       (item),
    .coords_in  (req_coords),
    .valid_out  (b_valid),
    .basis_out  (b_basis),
    .meta_out   (b_meta),
    .coords_out (b_coords)
  );

  hcpg_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .valid_in  (b_valid),
    .basis_in  (b_basis),
    .meta_in   (b_meta),
    .coords_in (b_coords),
    .valid_out (out_valid),
    .point_x   (out_ch.point_x),
    .point_y   (out_ch.point_y),
    .meta_out  (o_meta)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.point_index = o_meta.index;
  assign out_ch.is_last     = o_meta.last;
  assign out_ch.rejected    = o_meta.rejected;

endmodule

`default_nettype wire
